### rtl/lda_gibbs_token_sampler_core_macros.svh
// Assertion helpers used by the sampler core
`ifndef LDA_GIBBS_TOKEN_SAMPLER_CORE_MACROS_SVH
`define LDA_GIBBS_TOKEN_SAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define LGTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sampler check failed");

// next-cycle implication
`define LGTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler check failed");

`endif

### rtl/lgts_pkg.sv
package lgts_pkg;

	localparam int TOPIC_W    = 6;
	localparam int MAX_TOPICS = 64;
	localparam int NK_W       = 7;
	localparam int WORD_W     = 12;
	localparam int DOC_W      = 10;
	localparam int GRP_W      = 2;
	localparam int CNT_W      = 16;
	localparam int COUNT_BITS = 32;
	localparam int WT_W       = 48;
	localparam int OP_W       = 49;
	localparam int PROD_W     = 98;
	localparam int SUM_W      = 54;
	localparam int THR_W      = 86;
	localparam int RAND_W     = 32;
	localparam int VED_W      = 37;
	localparam int CLR_W      = WORD_W + TOPIC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {ST_OK, ST_NEG, ST_ZERO, ST_NONE} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA, REG_ETA, REG_VOCAB, REG_TOPICS, REG_FREEZE
	} reg_idx_t;

	typedef enum logic [1:0] {TSEL_CUR, TSEL_K, TSEL_SEL} tsel_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RDCUR, S_CHK, S_WRD, S_WAB, S_MUL, S_DIVI, S_DIV, S_WWR,
		S_SUMCHK, S_THR, S_BRD, S_ACC, S_CMP, S_URD, S_UWR, S_FIN
	} state_t;

	typedef struct packed {
		logic    clr;
		logic    load_in;
		tsel_t   tsel;
		logic    wr_remove;
		logic    wr_restore;
		logic    wr_update;
		logic    ab_load;
		logic    wt_const;
		logic    mul_run;
		logic    div_init;
		logic    div_run;
		logic    wt_write;
		logic    k_clear;
		logic    k_inc;
		logic    thr_mul;
		logic    thr_add;
		logic    cum_acc;
		logic    sel_load;
		logic    set_code;
		status_t code;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic underflow;
		logic un;
		logic sum_zero;
		logic mul_done;
		logic div_skip;
		logic div_done;
		logic k_last;
		logic hit;
		logic out_busy;
	} sts_t;

endpackage

### rtl/lgts_ctrl.sv
module lgts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lgts_pkg::sts_t sts,
	output lgts_pkg::cmd_t cmd
);
	import lgts_pkg::*;

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR:  if (sts.clr_done) state_n = S_IDLE;
			S_IDLE:   if (in_valid) state_n = S_RDCUR;
			S_RDCUR:  state_n = S_CHK;
			S_CHK: begin
				if (sts.un)             state_n = S_WRD;
				else if (sts.underflow) state_n = S_FIN;
				else                    state_n = S_WRD;
			end
			S_WRD:    state_n = S_WAB;
			S_WAB:    state_n = sts.un ? S_WWR : S_MUL;
			S_MUL:    if (sts.mul_done) state_n = S_DIVI;
			S_DIVI:   state_n = sts.div_skip ? S_WWR : S_DIV;
			S_DIV:    if (sts.div_done) state_n = S_WWR;
			S_WWR:    state_n = sts.k_last ? S_SUMCHK : S_WRD;
			S_SUMCHK: state_n = sts.sum_zero ? S_FIN : S_THR;
			S_THR:    state_n = S_BRD;
			S_BRD:    state_n = S_ACC;
			S_ACC:    state_n = S_CMP;
			S_CMP:    state_n = (sts.hit || sts.k_last) ? S_URD : S_BRD;
			S_URD:    state_n = S_UWR;
			S_UWR:    state_n = S_FIN;
			S_FIN:    if (!sts.out_busy) state_n = S_IDLE;
			default:  state_n = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.tsel = TSEL_CUR;
		cmd.code = ST_OK;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_RDCUR: cmd.tsel = TSEL_CUR;
			S_CHK: begin
				cmd.k_clear = 1'b1;
				if (!sts.un && sts.underflow) begin
					cmd.set_code = 1'b1;
					cmd.code     = ST_NEG;
				end else if (!sts.un) begin
					cmd.wr_remove = 1'b1;
				end
			end
			S_WRD: cmd.tsel = TSEL_K;
			S_WAB: begin
				cmd.wt_const = sts.un;
				cmd.ab_load  = !sts.un;
			end
			S_MUL:  cmd.mul_run  = 1'b1;
			S_DIVI: cmd.div_init = 1'b1;
			S_DIV:  cmd.div_run  = 1'b1;
			S_WWR: begin
				cmd.wt_write = 1'b1;
				cmd.k_inc    = !sts.k_last;
			end
			S_SUMCHK: begin
				if (sts.sum_zero) begin
					cmd.set_code   = 1'b1;
					cmd.code       = ST_ZERO;
					cmd.wr_restore = !sts.un;
				end else begin
					cmd.k_clear = 1'b1;
					cmd.thr_mul = 1'b1;
				end
			end
			S_THR: cmd.thr_add = 1'b1;
			S_BRD: cmd.tsel    = TSEL_K;
			S_ACC: cmd.cum_acc = 1'b1;
			S_CMP: begin
				if (sts.hit || sts.k_last) cmd.sel_load = 1'b1;
				else                       cmd.k_inc    = 1'b1;
			end
			S_URD: cmd.tsel = TSEL_SEL;
			S_UWR: begin
				cmd.tsel      = TSEL_SEL;
				cmd.wr_update = 1'b1;
			end
			S_FIN:   cmd.out_load = !sts.out_busy;
			default: cmd.clr = 1'b0;
		endcase
	end

endmodule

### rtl/lgts_dp.sv
module lgts_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lgts_pkg::cmd_t                     cmd,
	output lgts_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic [lgts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lgts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [lgts_pkg::DOC_W-1:0]        doc_index,
	input  logic [lgts_pkg::WORD_W-1:0]       word_index,
	input  logic [lgts_pkg::GRP_W-1:0]        word_group,
	input  logic [lgts_pkg::CNT_W-1:0]        token_count,
	input  logic                              is_unassigned,
	input  logic [lgts_pkg::TOPIC_W-1:0]      current_topic,
	input  logic                              has_initial,
	input  logic [lgts_pkg::TOPIC_W-1:0]      initial_topic,
	input  logic [lgts_pkg::RAND_W-1:0]       random_fraction,
	input  logic                              accumulate_expect,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lgts_pkg::TOPIC_W-1:0]      new_topic,
	output logic [1:0]                        status
);
	import lgts_pkg::*;

	localparam int WADDR_W = WORD_W + TOPIC_W;
	localparam int DADDR_W = DOC_W + TOPIC_W;
	localparam int GADDR_W = GRP_W + TOPIC_W;
	localparam int QHI_W   = PROD_W - WT_W;

	logic [COUNT_BITS-1:0] wmem [2**WADDR_W];
	logic [COUNT_BITS-1:0] gmem [2**GADDR_W];
	logic [COUNT_BITS-1:0] dmem [2**DADDR_W];
	logic [COUNT_BITS-1:0] emem [2**DADDR_W];
	logic [WT_W-1:0]       wbuf [MAX_TOPICS];

	logic [CFG_DATA_W-1:0] alpha_q, eta_q;
	logic [12:0]           vocab_q;
	logic [NK_W-1:0]       topics_q;
	logic                  frz_q;
	logic [VED_W-1:0]      ved_q;

	logic [DOC_W-1:0]   d_q;
	logic [WORD_W-1:0]  w_q;
	logic [GRP_W-1:0]   g_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               un_q, hinit_q, acc_q;
	logic [TOPIC_W-1:0] cur_q, init_q, k_q, sel_q;
	logic [RAND_W-1:0]  r_q;

	logic [CLR_W-1:0]      clr_q;
	logic [COUNT_BITS-1:0] wrd_q, grd_q, drd_q, erd_q, ow_q, og_q, od_q;
	logic [WT_W-1:0]       brd_q;

	logic [OP_W-1:0]   a_q, b_q, dn_q;
	logic [2:0]        mstep_q;
	logic [1:0]        sh_q;
	logic [63:0]       prod_q;
	logic [PROD_W-1:0] acc_prod_q;
	logic [OP_W-1:0]   rem_q;
	logic [WT_W-1:0]   plow_q, wt_q;
	logic [5:0]        dstep_q;
	logic [SUM_W-1:0]  sum_q, cum_q;
	logic [63:0]       p0_q;
	logic [SUM_W-1:0]  p1_q;
	logic [THR_W-1:0]  thr_q;
	status_t           code_q;
	logic              out_valid_q;
	logic [TOPIC_W-1:0] topic_q;
	status_t           stat_q;

	logic [TOPIC_W-1:0] tk;
	logic [WADDR_W-1:0] waddr;
	logic [GADDR_W-1:0] gaddr;
	logic [DADDR_W-1:0] daddr;
	logic [NK_W-1:0]    nk;
	logic [COUNT_BITS-1:0] cnt_ext, wsat, gsat, dsat, esat, wwd, gwd, dwd, ewd;
	logic               w_we, g_we, d_we, e_we, anyw;
	logic [31:0]        ma, mb;
	logic [QHI_W-1:0]   qhi;
	logic [OP_W:0]      dtry;
	logic               dge;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v,
		input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS:0] s;
		s = {1'b0, v} + {1'b0, c};
		return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= CFG_DATA_W'(65536);
			eta_q    <= CFG_DATA_W'(65536);
			vocab_q  <= 13'd4096;
			topics_q <= NK_W'(8);
			frz_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ALPHA:  alpha_q  <= cfg_data;
				REG_ETA:    eta_q    <= cfg_data;
				REG_VOCAB:  vocab_q  <= cfg_data[12:0];
				REG_TOPICS: topics_q <= cfg_data[NK_W-1:0];
				REG_FREEZE: frz_q    <= cfg_data[0];
				default:    frz_q    <= frz_q;
			endcase
		end
	end

	always_ff @(posedge clk) ved_q <= vocab_q * eta_q;

	always_comb begin
		if (topics_q == '0)                     nk = NK_W'(1);
		else if (topics_q > NK_W'(MAX_TOPICS))  nk = NK_W'(MAX_TOPICS);
		else                                    nk = topics_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			d_q     <= doc_index;
			w_q     <= word_index;
			g_q     <= word_group;
			cnt_q   <= token_count;
			un_q    <= is_unassigned;
			cur_q   <= current_topic;
			hinit_q <= has_initial;
			init_q  <= initial_topic;
			r_q     <= random_fraction;
			acc_q   <= accumulate_expect;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      clr_q <= '0;
		else if (cmd.clr) clr_q <= clr_q + CLR_W'(1);
	end

	always_comb begin
		unique case (cmd.tsel)
			TSEL_CUR: tk = cur_q;
			TSEL_K:   tk = k_q;
			TSEL_SEL: tk = sel_q;
			default:  tk = cur_q;
		endcase
	end

	assign waddr = cmd.clr ? clr_q : {w_q, tk};
	assign gaddr = cmd.clr ? clr_q[GADDR_W-1:0] : {g_q, tk};
	assign daddr = cmd.clr ? clr_q[DADDR_W-1:0] : {d_q, tk};

	assign cnt_ext = COUNT_BITS'(cnt_q);
	assign wsat = sat_add(wrd_q, cnt_ext);
	assign gsat = sat_add(grd_q, cnt_ext);
	assign dsat = sat_add(drd_q, cnt_ext);
	assign esat = sat_add(erd_q, cnt_ext);

	assign anyw = cmd.wr_remove || cmd.wr_restore || cmd.wr_update;
	assign w_we = cmd.clr || (!frz_q && anyw);
	assign g_we = w_we;
	assign d_we = cmd.clr || anyw;
	assign e_we = cmd.clr || (cmd.wr_update && acc_q);

	always_comb begin
		wwd = '0; gwd = '0; dwd = '0; ewd = '0;
		priority if (cmd.clr) begin
			wwd = '0; gwd = '0; dwd = '0; ewd = '0;
		end else if (cmd.wr_remove) begin
			wwd = wrd_q - cnt_ext;
			gwd = grd_q - cnt_ext;
			dwd = drd_q - cnt_ext;
		end else if (cmd.wr_restore) begin
			wwd = ow_q; gwd = og_q; dwd = od_q;
		end else if (cmd.wr_update) begin
			wwd = wsat; gwd = gsat; dwd = dsat; ewd = esat;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[waddr] <= wwd;
		wrd_q <= wmem[waddr];
	end

	always_ff @(posedge clk) begin
		if (g_we) gmem[gaddr] <= gwd;
		grd_q <= gmem[gaddr];
	end

	always_ff @(posedge clk) begin
		if (d_we) dmem[daddr] <= dwd;
		drd_q <= dmem[daddr];
	end

	always_ff @(posedge clk) begin
		if (e_we) emem[daddr] <= ewd;
		erd_q <= emem[daddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wt_write) wbuf[k_q] <= wt_q;
		brd_q <= wbuf[k_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_remove) begin
			ow_q <= wrd_q;
			og_q <= grd_q;
			od_q <= drd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          k_q <= '0;
		else if (cmd.k_clear) k_q <= '0;
		else if (cmd.k_inc)   k_q <= k_q + TOPIC_W'(1);
	end

	always_comb begin
		unique case (mstep_q[1:0])
			2'd0: begin ma = a_q[31:0];                 mb = b_q[31:0]; end
			2'd1: begin ma = a_q[31:0];                 mb = 32'(b_q[OP_W-1:32]); end
			2'd2: begin ma = 32'(a_q[OP_W-1:32]);       mb = b_q[31:0]; end
			default: begin ma = 32'(a_q[OP_W-1:32]);    mb = 32'(b_q[OP_W-1:32]); end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ab_load) begin
			a_q        <= {1'b0, drd_q, 16'h0} + OP_W'(alpha_q);
			b_q        <= {1'b0, wrd_q, 16'h0} + OP_W'(eta_q);
			dn_q       <= {1'b0, grd_q, 16'h0} + OP_W'(ved_q);
			mstep_q    <= '0;
			acc_prod_q <= '0;
		end else if (cmd.mul_run) begin
			if (mstep_q != 3'd4) begin
				prod_q <= ma * mb;
				sh_q   <= mstep_q[1:0];
			end
			if (mstep_q != 3'd0) begin
				unique case (sh_q)
					2'd0:    acc_prod_q <= acc_prod_q + PROD_W'(prod_q);
					2'd3:    acc_prod_q <= acc_prod_q + PROD_W'({prod_q, 64'h0});
					default: acc_prod_q <= acc_prod_q + PROD_W'({prod_q, 32'h0});
				endcase
			end
			mstep_q <= mstep_q + 3'd1;
		end
	end

	assign qhi  = acc_prod_q[PROD_W-1:WT_W];
	assign dtry = {rem_q, plow_q[WT_W-1]};
	assign dge  = dtry >= {1'b0, dn_q};

	always_ff @(posedge clk) begin
		if (cmd.wt_const) begin
			wt_q <= (!hinit_q || init_q == k_q) ? WT_W'(65536) : '0;
		end else if (cmd.div_init) begin
			dstep_q <= '0;
			rem_q   <= qhi[OP_W-1:0];
			plow_q  <= acc_prod_q[WT_W-1:0];
			if (dn_q == '0)                     wt_q <= (acc_prod_q != '0) ? '1 : '0;
			else if (qhi >= QHI_W'(dn_q))       wt_q <= '1;
			else                                wt_q <= '0;
		end else if (cmd.div_run) begin
			rem_q   <= dge ? OP_W'(dtry - {1'b0, dn_q}) : dtry[OP_W-1:0];
			plow_q  <= {plow_q[WT_W-2:0], 1'b0};
			wt_q    <= {wt_q[WT_W-2:0], dge};
			dstep_q <= dstep_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)       sum_q <= '0;
		else if (cmd.wt_write) sum_q <= sum_q + SUM_W'(wt_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.thr_mul) begin
			p0_q <= r_q * sum_q[31:0];
			p1_q <= r_q * sum_q[SUM_W-1:32];
		end
		if (cmd.thr_add) thr_q <= THR_W'(p0_q) + {p1_q, 32'h0};
		if (cmd.k_clear)      cum_q <= '0;
		else if (cmd.cum_acc) cum_q <= cum_q + SUM_W'(brd_q);
		if (cmd.sel_load) sel_q <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           code_q <= ST_OK;
		else if (cmd.load_in)  code_q <= ST_OK;
		else if (cmd.set_code) code_q <= cmd.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready)    out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			topic_q <= (code_q == ST_OK) ? sel_q : '0;
			stat_q  <= code_q;
		end
	end

	assign out_valid = out_valid_q;
	assign new_topic = topic_q;
	assign status    = stat_q;

	always_comb begin
		sts.clr_done  = &clr_q;
		sts.underflow = (drd_q < cnt_ext) || (!frz_q && (wrd_q < cnt_ext || grd_q < cnt_ext));
		sts.un        = un_q;
		sts.sum_zero  = sum_q == '0;
		sts.mul_done  = mstep_q == 3'd4;
		sts.div_skip  = (dn_q == '0) || (qhi >= QHI_W'(dn_q));
		sts.div_done  = dstep_q == 6'(WT_W - 1);
		sts.k_last    = {1'b0, k_q} == nk - NK_W'(1);
		sts.hit       = thr_q < {cum_q, 32'h0};
		sts.out_busy  = out_valid_q && !out_ready;
	end

endmodule

### rtl/lda_gibbs_token_sampler_core.sv
// Topic resampler for collapsed Gibbs sampling, one token word per accepted input.
// Input channel (in_valid/in_ready): one token; the core takes one word at a time.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects alpha, eta,
// vocabulary size, topic count or freeze; write only while the core is idle.
// Output channel (out_valid/out_ready): new_topic and status per token.
// Per topic, an assigned token gets its weight from the split multiplier and the
// bit-serial divider; an unassigned token gets a fixed weight instead. Either kind
// then walks the topics for the cumulative pick. For an assigned token the divider
// is skipped where a quotient saturates or the denominator is zero.
// After reset the count tables are swept to zero, one entry a cycle, over all 262144
// word-table addresses; in_ready stays low during the sweep.
// The result sits in an output register; a stalled receiver holds it there while
// the next token is already accepted and processed; a new result waits until the
// register is taken.
module lda_gibbs_token_sampler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lgts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lgts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lgts_pkg::DOC_W-1:0]        doc_index,
	input  logic [lgts_pkg::WORD_W-1:0]       word_index,
	input  logic [lgts_pkg::GRP_W-1:0]        word_group,
	input  logic [lgts_pkg::CNT_W-1:0]        token_count,
	input  logic                              is_unassigned,
	input  logic [lgts_pkg::TOPIC_W-1:0]      current_topic,
	input  logic                              has_initial,
	input  logic [lgts_pkg::TOPIC_W-1:0]      initial_topic,
	input  logic [lgts_pkg::RAND_W-1:0]       random_fraction,
	input  logic                              accumulate_expect,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lgts_pkg::TOPIC_W-1:0]      new_topic,
	output logic [1:0]                        status
);
	import lgts_pkg::*;
	`include "lda_gibbs_token_sampler_core_macros.svh"

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lgts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lgts_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.doc_index         (doc_index),
		.word_index        (word_index),
		.word_group        (word_group),
		.token_count       (token_count),
		.is_unassigned     (is_unassigned),
		.current_topic     (current_topic),
		.has_initial       (has_initial),
		.initial_topic     (initial_topic),
		.random_fraction   (random_fraction),
		.accumulate_expect (accumulate_expect),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.new_topic         (new_topic),
		.status            (status)
	);

	`LGTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`LGTS_ASSERT_NOW(a_err_topic_zero, out_valid && status != ST_OK, new_topic == '0)
	`LGTS_ASSERT_NOW(a_no_none_status, out_valid, status != ST_NONE)
	`LGTS_ASSERT_NEXT(a_result_after_work, in_valid && in_ready, !(cmd.out_load))

endmodule
